### sv/tcpcs_pkg.sv
// Package for the TCP checksum unit with the IPv4 pseudo-header.
// Holds the shared constants and the record passed from the accumulator to the finish stage.
// No dependencies.
`default_nettype none

package tcpcs_pkg;

  localparam int unsigned WORD_W  = 16;
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned PSUM_W  = 19;

  localparam logic [COUNT_W-1:0] CHECK_FIELD_OFFSET = 17'd16;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT        = 17'h10000;
  localparam logic [WORD_W-1:0]  TCP_PROTO_WORD     = 16'h0006;
  localparam logic [WORD_W-1:0]  LEN_MAX            = 16'hffff;

  typedef struct packed {
    logic [WORD_W-1:0] seg_sum;
    logic [PSUM_W-1:0] addr_sum;
    logic [WORD_W-1:0] seg_len;
    logic              len_ovf;
  } mid_t;

endpackage

`default_nettype wire

### sv/tcpcs_if.sv
// Channel interfaces for the TCP checksum unit: segment words in, results out.
// Each carries valid, ready and the payload fields; no dependencies.
`default_nettype none

interface tcpcs_seg_if;
  logic        valid;
  logic        ready;
  logic [15:0] segment_word;
  logic        high_byte_only;
  logic        first_word;
  logic        last_word;
  logic [31:0] source_address;
  logic [31:0] dest_address;

  modport source (
    output valid, segment_word, high_byte_only, first_word, last_word,
           source_address, dest_address,
    input  ready
  );
  modport sink (
    input  valid, segment_word, high_byte_only, first_word, last_word,
           source_address, dest_address,
    output ready
  );
endinterface

interface tcpcs_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] checksum_value;
  logic [15:0] segment_length;
  logic        length_overflow;

  modport source (
    output valid, checksum_value, segment_length, length_overflow,
    input  ready
  );
  modport sink (
    input  valid, checksum_value, segment_length, length_overflow,
    output ready
  );
endinterface

`default_nettype wire

### sv/tcpcs_accum.sv
// Input register and running one's-complement accumulator with byte counter.
// Emits one mid_t record per segment on its last word. Depends on tcpcs_pkg and tcpcs_if.
`default_nettype none

module tcpcs_accum
  import tcpcs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  tcpcs_seg_if.sink     segment,
  output logic          mid_valid,
  input  wire logic     mid_ready,
  output mid_t          mid_data
);

  logic                in_valid;
  logic [WORD_W-1:0]   in_word;
  logic                in_half;
  logic                in_first;
  logic                in_last;
  logic [ADDR_W-1:0]   in_src;
  logic [ADDR_W-1:0]   in_dst;

  logic [WORD_W-1:0]   acc;
  logic [COUNT_W-1:0]  byte_count;
  logic [PSUM_W-1:0]   addr_sum;

  logic                consume;
  logic [WORD_W-1:0]   base_acc;
  logic [COUNT_W-1:0]  base_cnt;
  logic [WORD_W-1:0]   add_word;
  logic [WORD_W:0]     raw_sum;
  logic [WORD_W-1:0]   acc_next;
  logic [COUNT_W-1:0]  cnt_sum;
  logic [COUNT_W-1:0]  byte_count_next;
  logic [PSUM_W-1:0]   addr_sum_next;
  logic [WORD_W-1:0]   len_out;

  assign consume       = in_valid && (!in_last || !mid_valid || mid_ready);
  assign segment.ready = !in_valid || consume;

  always_comb begin
    base_acc = in_first ? '0 : acc;
    base_cnt = in_first ? '0 : byte_count;
    if (base_cnt == CHECK_FIELD_OFFSET) begin
      add_word = '0;
    end else if (in_half) begin
      add_word = {in_word[15:8], 8'h00};
    end else begin
      add_word = in_word;
    end
    raw_sum  = {1'b0, base_acc} + {1'b0, add_word};
    acc_next = raw_sum[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, raw_sum[WORD_W]};

    cnt_sum = base_cnt + (in_half ? 17'd1 : 17'd2);
    byte_count_next = (cnt_sum > COUNT_LIMIT) ? COUNT_LIMIT : cnt_sum;
    len_out = byte_count_next[16] ? LEN_MAX : byte_count_next[15:0];

    if (in_first) begin
      addr_sum_next = PSUM_W'(in_src[31:16]) + PSUM_W'(in_src[15:0])
                    + PSUM_W'(in_dst[31:16]) + PSUM_W'(in_dst[15:0])
                    + PSUM_W'(TCP_PROTO_WORD);
    end else begin
      addr_sum_next = addr_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (segment.ready) begin
      in_valid <= segment.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (segment.valid && segment.ready) begin
      in_word  <= segment.segment_word;
      in_half  <= segment.high_byte_only;
      in_first <= segment.first_word;
      in_last  <= segment.last_word;
      in_src   <= segment.source_address;
      in_dst   <= segment.dest_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      byte_count <= '0;
      addr_sum   <= PSUM_W'(TCP_PROTO_WORD);
    end else if (consume) begin
      addr_sum <= addr_sum_next;
      if (in_last) begin
        acc        <= '0;
        byte_count <= '0;
      end else begin
        acc        <= acc_next;
        byte_count <= byte_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (consume && in_last) begin
      mid_valid <= 1'b1;
    end else if (mid_ready) begin
      mid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && in_last) begin
      mid_data.seg_sum  <= acc_next;
      mid_data.addr_sum <= addr_sum_next;
      mid_data.seg_len  <= len_out;
      mid_data.len_ovf  <= byte_count_next[16];
    end
  end

endmodule

`default_nettype wire

### sv/tcpcs_finish.sv
// Adds the pseudo-header and length to the segment sum, folds, complements and registers the result.
// Depends on tcpcs_pkg and tcpcs_if.
`default_nettype none

module tcpcs_finish
  import tcpcs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     mid_valid,
  output logic          mid_ready,
  input  mid_t          mid_data,
  tcpcs_res_if.source   result
);

  logic                out_valid;
  logic [WORD_W-1:0]   out_sum;
  logic [WORD_W-1:0]   out_len;
  logic                out_ovf;

  logic [PSUM_W-1:0]   total;
  logic [WORD_W:0]     fold_a;
  logic [WORD_W-1:0]   fold_b;

  assign mid_ready = !out_valid || result.ready;

  always_comb begin
    total  = PSUM_W'(mid_data.seg_sum) + mid_data.addr_sum + PSUM_W'(mid_data.seg_len);
    fold_a = {1'b0, total[WORD_W-1:0]} + (WORD_W+1)'(total[PSUM_W-1:WORD_W]);
    fold_b = fold_a[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, fold_a[WORD_W]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mid_ready) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_valid && mid_ready) begin
      out_sum <= ~fold_b;
      out_len <= mid_data.seg_len;
      out_ovf <= mid_data.len_ovf;
    end
  end

  assign result.valid           = out_valid;
  assign result.checksum_value  = out_sum;
  assign result.segment_length  = out_len;
  assign result.length_overflow = out_ovf;

endmodule

`default_nettype wire

### sv/tcp_checksum_pseudo_header_unit.sv
// TCP checksum unit with IPv4 pseudo-header, one 16-bit segment word per transaction.
// Throughput: one word every cycle while no last word waits on a stalled record.
// A last word passes the input, record and result registers before its result is offered.
// Back-pressure on the result channel stalls the pipeline only when results are waiting.
// Synchronous reset clears all valid flags, the accumulator and the byte count, and loads
// the address sum with the protocol word alone.
// Depends on tcpcs_pkg, tcpcs_if, tcpcs_accum and tcpcs_finish.
`default_nettype none

module tcp_checksum_pseudo_header_unit
  import tcpcs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  tcpcs_seg_if.sink     segment,
  tcpcs_res_if.source   result
);

  logic mid_valid;
  logic mid_ready;
  mid_t mid_data;

  tcpcs_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .segment   (segment),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid_data  (mid_data)
  );

  tcpcs_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid_data  (mid_data),
    .result    (result)
  );

  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    mid_valid && !mid_ready |=> mid_valid && $stable(mid_data))
    else $error("Pending record changed while stalled.");

  a_ovf_len: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.length_overflow |-> result.segment_length == LEN_MAX)
    else $error("Overflowed length is not saturated.");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.segment_length != '0)
    else $error("Result carries a zero segment length.");

endmodule

`default_nettype wire

### bench/tb_top.sv
// Self-checking testbench for tcp_checksum_pseudo_header_unit, with directed and random segments.
// Predicts each checksum result and compares it with the result channel under random idling.
// Depends on tcpcs_pkg, tcpcs_if and the unit's RTL.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcpcs_pkg::*;

  localparam int RUN_LIMIT    = 1_000_000;
  localparam int RANDOM_ITEMS = 1580;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [15:0] checksum;
    logic [15:0] length;
    logic        overflow;
  } tcp_result_t;

  logic clk;
  logic rst;

  tcpcs_seg_if seg_ch ();
  tcpcs_res_if res_ch ();

  tcp_checksum_pseudo_header_unit dut (
    .clk     (clk),
    .rst     (rst),
    .segment (seg_ch),
    .result  (res_ch)
  );

  tcp_result_t expected_results[$];

  logic [31:0]        acc_sum;
  logic [COUNT_W-1:0] acc_bytes;
  logic [31:0]        held_src;
  logic [31:0]        held_dst;

  int mismatches;
  int cycle_count;
  int words_sent;
  int burst_left;
  int stall_left;
  int stall_mode;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("tcp_checksum_pseudo_header_unit test failed");
      $finish;
    end
  end

  function automatic logic [31:0] ones_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[31:0] + {31'd0, s[32]};
  endfunction

  function automatic void accumulate_word(input logic [15:0] w, input logic half,
                                          input logic first, input logic last,
                                          input logic [31:0] src, input logic [31:0] dst);
    logic [31:0]        addend;
    logic [31:0]        total;
    logic [15:0]        len;
    logic [COUNT_W-1:0] next_bytes;
    tcp_result_t        res;
    if (first) begin
      acc_sum   = '0;
      acc_bytes = '0;
      held_src  = src;
      held_dst  = dst;
    end
    addend = half ? {16'd0, w[15:8], 8'h00} : {16'd0, w};
    if (acc_bytes == CHECK_FIELD_OFFSET)
      addend = '0;
    acc_sum = ones_add(acc_sum, addend);
    next_bytes = acc_bytes + (half ? 17'd1 : 17'd2);
    acc_bytes = (next_bytes > COUNT_LIMIT) ? COUNT_LIMIT : next_bytes;
    if (!last)
      return;
    len   = (acc_bytes > {1'b0, LEN_MAX}) ? LEN_MAX : acc_bytes[15:0];
    total = ones_add(acc_sum, {16'd0, held_src[31:16]});
    total = ones_add(total, {16'd0, held_src[15:0]});
    total = ones_add(total, {16'd0, held_dst[31:16]});
    total = ones_add(total, {16'd0, held_dst[15:0]});
    total = ones_add(total, {16'd0, TCP_PROTO_WORD});
    total = ones_add(total, {16'd0, len});
    while (total[31:16] != 16'd0)
      total = {16'd0, total[15:0]} + {16'd0, total[31:16]};
    res.checksum = ~total[15:0];
    res.length   = len;
    res.overflow = (acc_bytes > {1'b0, LEN_MAX});
    expected_results.push_back(res);
    acc_sum   = '0;
    acc_bytes = '0;
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_addr();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [15:0] w, input logic half, input logic first,
                           input logic last, input logic [31:0] src, input logic [31:0] dst);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
        seg_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 12);
    end
    burst_left--;
    seg_ch.valid          <= 1'b1;
    seg_ch.segment_word   <= w;
    seg_ch.high_byte_only <= half;
    seg_ch.first_word     <= first;
    seg_ch.last_word      <= last;
    seg_ch.source_address <= src;
    seg_ch.dest_address   <= dst;
    do @(posedge clk); while (seg_ch.ready !== 1'b1);
    accumulate_word(w, half, first, last, src, dst);
    words_sent++;
  endtask

  // The receiver moves between phases: always ready, mostly ready, mostly stalled, periodic.
  always @(posedge clk) begin
    tcp_result_t want;
    tcp_result_t got;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 400);
      end
      stall_left--;
      case (stall_mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= ($urandom_range(0, 3) != 0);
        2: res_ch.ready <= ($urandom_range(0, 3) == 0);
        default: res_ch.ready <= (cycle_count[2:0] != 3'd0);
      endcase
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        got.checksum = res_ch.checksum_value;
        got.length   = res_ch.segment_length;
        got.overflow = res_ch.length_overflow;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("Unexpected result transaction: checksum %h length %0d overflow %b",
                     got.checksum, got.length, got.overflow);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("Result mismatch: expected checksum %h length %0d overflow %b, got %h %0d %b",
                       want.checksum, want.length, want.overflow,
                       got.checksum, got.length, got.overflow);
          end
        end
      end
    end
  end

  task automatic test_no_first_after_reset();
    send_word(16'h1234, 1'b0, 1'b0, 1'b1, $urandom, $urandom);
  endtask

  task automatic test_field_extremes();
    send_word(16'h0000, 1'b0, 1'b1, 1'b1, 32'hffff_ffff, 32'hffff_ffff);
    send_word(16'hffff, 1'b0, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000);
    send_word(16'hffff, 1'b1, 1'b1, 1'b1, 32'hffff_ffff, 32'h0000_0000);
  endtask

  task automatic test_zero_sum();
    send_word(16'hfff7, 1'b0, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000);
  endtask

  task automatic test_checksum_field();
    logic [31:0] src;
    logic [31:0] dst;
    src = rand_addr();
    dst = rand_addr();
    for (int i = 0; i < 9; i++)
      send_word((i == 8) ? 16'hbeef : rand_word(), 1'b0, i == 0, i == 8, src, dst);
  endtask

  task automatic test_odd_byte_midsegment();
    logic [31:0] src;
    logic [31:0] dst;
    src = rand_addr();
    dst = rand_addr();
    send_word(16'hab5a, 1'b1, 1'b1, 1'b0, src, dst);
    for (int i = 0; i < 3; i++)
      send_word(rand_word(), 1'b0, 1'b0, i == 2, src, dst);
  endtask

  task automatic test_restart_midsegment();
    send_word(rand_word(), 1'b0, 1'b1, 1'b0, rand_addr(), rand_addr());
    send_word(rand_word(), 1'b0, 1'b0, 1'b0, rand_addr(), rand_addr());
    send_word(rand_word(), 1'b0, 1'b1, 1'b1, rand_addr(), rand_addr());
  endtask

  // One long segment of full words that ends on an odd byte.
  task automatic test_long_segments();
    logic [31:0] src;
    logic [31:0] dst;
    src = rand_addr();
    dst = rand_addr();
    for (int i = 0; i < 200; i++)
      send_word(16'($urandom), 1'b0, i == 0, 1'b0, src, dst);
    send_word(16'($urandom), 1'b1, 1'b0, 1'b1, src, dst);
  endtask

  task automatic test_random_segments();
    int          stop_at;
    int          kind;
    int          nwords;
    logic        odd_tail;
    logic        first;
    logic        last;
    logic        half;
    logic [31:0] src;
    logic [31:0] dst;
    stop_at = words_sent + RANDOM_ITEMS;
    while (words_sent < stop_at) begin
      kind     = $urandom_range(0, 9);
      nwords   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 14);
      odd_tail = ($urandom_range(0, 2) == 0);
      src      = rand_addr();
      dst      = rand_addr();
      for (int i = 0; i < nwords; i++) begin
        if (kind == 9) begin
          first = ($urandom_range(0, 7) == 0);
          last  = ($urandom_range(0, 5) == 0);
          half  = ($urandom_range(0, 3) == 0);
        end else begin
          first = (kind != 8) && (i == 0);
          last  = (i == nwords - 1);
          half  = last ? odd_tail : ($urandom_range(0, 19) == 0);
        end
        send_word(rand_word(), half, first, last, src, dst);
      end
    end
  endtask

  initial begin
    rst                   = 1'b1;
    seg_ch.valid          = 1'b0;
    seg_ch.segment_word   = '0;
    seg_ch.high_byte_only = 1'b0;
    seg_ch.first_word     = 1'b0;
    seg_ch.last_word      = 1'b0;
    seg_ch.source_address = '0;
    seg_ch.dest_address   = '0;
    res_ch.ready          = 1'b0;
    acc_sum               = '0;
    acc_bytes             = '0;
    held_src              = '0;
    held_dst              = '0;
    mismatches            = 0;
    cycle_count           = 0;
    words_sent            = 0;
    burst_left            = 0;
    stall_left            = 0;
    stall_mode            = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_no_first_after_reset();
    test_field_extremes();
    test_zero_sum();
    test_checksum_field();
    test_odd_byte_midsegment();
    test_restart_midsegment();
    test_long_segments();
    test_random_segments();

    seg_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tcp_checksum_pseudo_header_unit test passed");
    end else begin
      $display("tcp_checksum_pseudo_header_unit test failed");
    end
    $finish;
  end

endmodule
